// ===== hdl/lupf_pkg.sv =====
// ----------------------------------------------------------------------------
// lupf_pkg
// Types, constants and helper functions for the location URL private filter.
// ----------------------------------------------------------------------------
package lupf_pkg;

	localparam int MAX_URL_LEN = 512;
	localparam int CNT_W       = $clog2(MAX_URL_LEN + 2);

	typedef logic [CNT_W-1:0] cnt_t;

	localparam cnt_t CNT_SAT = CNT_W'(MAX_URL_LEN + 1);
	localparam cnt_t CNT_MAX = CNT_W'(MAX_URL_LEN);

	typedef enum logic [2:0] {
		PH_PREFIX = 3'b001,
		PH_AUTH   = 3'b010,
		PH_REST   = 3'b100
	} phase_t;

	typedef enum logic [3:0] {
		PS_NONE   = 4'b0001,
		PS_COLON  = 4'b0010,
		PS_DIGITS = 4'b0100,
		PS_BAD    = 4'b1000
	} pstat_t;

	typedef enum logic [2:0] {
		VC_OK         = 3'd0,
		VC_TOO_LONG   = 3'd1,
		VC_BAD_SCHEME = 3'd2,
		VC_EMPTY_AUTH = 3'd3,
		VC_BAD_PORT   = 3'd4,
		VC_EMPTY_HOST = 3'd5,
		VC_NOT_IPV4   = 3'd6,
		VC_PUBLIC     = 3'd7
	} verdict_t;

	localparam logic [15:0] DEFAULT_PORT = 16'd80;
	localparam logic [16:0] PORT_SAT     = 17'd65536;
	localparam logic [16:0] PORT_MAX     = 17'd65535;

	typedef struct packed {
		logic [31:0] addr;
		logic [9:0]  accum;
		logic [2:0]  digits;
		logic [2:0]  index;
		logic        bad;
	} host_t;

	typedef struct packed {
		cnt_t        char_count;
		phase_t      phase;
		logic        scheme_match;
		host_t       host;
		logic        auth_ne;
		logic        host_ne;
		logic [16:0] port_accum;
		pstat_t      port_status;
	} parse_state_t;

	typedef struct packed {
		verdict_t    code;
		logic [31:0] addr;
		logic [15:0] port;
	} verdict_res_t;

	function automatic parse_state_t state_reset();
		parse_state_t s;
		s              = '0;
		s.phase        = PH_PREFIX;
		s.scheme_match = 1'b1;
		s.port_status  = PS_NONE;
		return s;
	endfunction

	function automatic logic [7:0] scheme_char(logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h68;
			3'd1: c = 8'h74;
			3'd2: c = 8'h74;
			3'd3: c = 8'h70;
			3'd4: c = 8'h3a;
			3'd5: c = 8'h2f;
			3'd6: c = 8'h2f;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic host_t host_close(host_t h);
		host_t r;
		r = h;
		if (!h.bad) begin
			if (h.digits == 3'd0 || h.digits > 3'd3 || h.index > 3'd3 ||
			    h.accum > 10'd255) begin
				r.bad = 1'b1;
			end else begin
				r.addr   = {h.addr[23:0], h.accum[7:0]};
				r.index  = h.index + 3'd1;
				r.accum  = '0;
				r.digits = '0;
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/lupf_step.sv =====
// ----------------------------------------------------------------------------
// lupf_step
// Per-byte parser update and end-of-URL verdict, purely combinational.
// ----------------------------------------------------------------------------
module lupf_step
	import lupf_pkg::*;
(
	input  parse_state_t st,
	input  logic [7:0]   url_byte,
	output parse_state_t st_next,
	output verdict_res_t res
);

	logic        is_digit;
	logic [3:0]  digit;
	logic [19:0] port_mul;
	host_t       host_fin;

	assign is_digit = (url_byte >= 8'h30) && (url_byte <= 8'h39);
	assign digit    = url_byte[3:0];
	assign port_mul = {3'b000, st.port_accum} * 20'd10 + {16'h0000, digit};

	always_comb begin
		st_next = st;
		if (st.char_count < CNT_SAT) begin
			st_next.char_count = st.char_count + 1'b1;
		end
		case (st.phase)
			PH_PREFIX: begin
				if (url_byte != scheme_char(st.char_count[2:0])) begin
					st_next.scheme_match = 1'b0;
				end
				if (st.char_count >= CNT_W'(6)) begin
					st_next.phase = PH_AUTH;
				end
			end
			PH_AUTH: begin
				if (url_byte == 8'h2f || url_byte == 8'h3f || url_byte == 8'h23) begin
					st_next.phase = PH_REST;
				end else begin
					st_next.auth_ne = 1'b1;
					if (st.port_status != PS_NONE) begin
						if (st.port_status != PS_BAD) begin
							if (is_digit) begin
								st_next.port_status = PS_DIGITS;
								if (port_mul > {3'b000, PORT_SAT}) begin
									st_next.port_accum = PORT_SAT;
								end else begin
									st_next.port_accum = port_mul[16:0];
								end
							end else begin
								st_next.port_status = PS_BAD;
							end
						end
					end else if (url_byte == 8'h3a) begin
						st_next.port_status = PS_COLON;
					end else begin
						st_next.host_ne = 1'b1;
						if (!st.host.bad) begin
							if (is_digit) begin
								if (st.host.digits < 3'd3) begin
									st_next.host.accum = st.host.accum * 10'd10 +
										{6'b000000, digit};
								end
								if (st.host.digits < 3'd4) begin
									st_next.host.digits = st.host.digits + 3'd1;
								end
								if (st.host.digits >= 3'd3) begin
									st_next.host.bad = 1'b1;
								end
							end else if (url_byte == 8'h2e) begin
								st_next.host = host_close(st.host);
							end else begin
								st_next.host.bad = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	// verdict on the updated state
	assign host_fin = host_close(st_next.host);

	always_comb begin
		res = '{code: VC_OK, addr: 32'h0, port: 16'h0};
		if (st_next.char_count > CNT_MAX) begin
			res.code = VC_TOO_LONG;
		end else if (st_next.char_count <= CNT_W'(7) || !st_next.scheme_match) begin
			res.code = VC_BAD_SCHEME;
		end else if (!st_next.auth_ne) begin
			res.code = VC_EMPTY_AUTH;
		end else if (st_next.port_status != PS_NONE &&
		             (st_next.port_status != PS_DIGITS || st_next.port_accum == 17'd0 ||
		              st_next.port_accum > PORT_MAX)) begin
			res.code = VC_BAD_PORT;
		end else begin
			res.port = (st_next.port_status == PS_NONE) ? DEFAULT_PORT :
				st_next.port_accum[15:0];
			if (!st_next.host_ne) begin
				res.code = VC_EMPTY_HOST;
			end else if (host_fin.bad || host_fin.index != 3'd4) begin
				res.code = VC_NOT_IPV4;
			end else begin
				res.addr = host_fin.addr;
				if (host_fin.addr[31:24] == 8'd10 ||
				    (host_fin.addr[31:24] == 8'd172 && host_fin.addr[23:16] >= 8'd16 &&
				     host_fin.addr[23:16] <= 8'd31) ||
				    (host_fin.addr[31:24] == 8'd192 && host_fin.addr[23:16] == 8'd168) ||
				    (host_fin.addr[31:24] == 8'd169 && host_fin.addr[23:16] == 8'd254)) begin
					res.code = VC_OK;
				end else begin
					res.code = VC_PUBLIC;
				end
			end
		end
	end

endmodule

// ===== hdl/location_url_private_filter.sv =====
// ----------------------------------------------------------------------------
// location_url_private_filter
// Streams a location URL byte by byte and gives one verdict per URL: http
// scheme, valid port and a dotted-quad host inside a private IPv4 range.
// ----------------------------------------------------------------------------
// the tlast byte is registered at input, its verdict in the result register
// throughput: one byte per cycle, set by the single input and result register,
// but the input holds, only while a verdict waits in the result register
// reset: arst_n clears the stage valids and all parser state at once
// parser state returns to its reset values after every last byte
module location_url_private_filter
	import lupf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] url_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // [0] accepted, [3:1] verdict_code,
	                               // [35:4] host_address, [51:36] port_number
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	parse_state_t state_q;
	parse_state_t state_next;
	verdict_res_t res;
	logic         adv;
	logic         m_valid_q;
	logic [55:0]  m_data_q;

	assign adv      = valid_s1 && (!last_s1 || !m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	lupf_step u_step (
		.st       (state_q),
		.url_byte (byte_s1),
		.st_next  (state_next),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= state_reset();
		end else if (adv) begin
			state_q <= last_s1 ? state_reset() : state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			m_data_q <= {4'h0, res.port, res.addr, res.code, res.code == VC_OK};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_verdict_shown: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> m_tvalid)
		else $error("verdict not shown after last byte");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && last_s1 && m_valid_q && !m_tready)
		else $error("input stalled without a waiting verdict");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> state_q.char_count == '0 && state_q.phase == PH_PREFIX &&
			state_q.port_status == PS_NONE)
		else $error("parser state not cleared after verdict");

	a_accept_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[0] == (m_tdata[3:1] == VC_OK))
		else $error("accepted flag disagrees with verdict code");

endmodule
